// ===== sv/lztd_pkg.sv =====
`timescale 1ns / 1ps
// Types and codes shared by the triad decompressor modules.
// No dependencies.
package lztd_pkg;

    localparam int CNT_W = 9;

    localparam logic CFG_WIDE   = 1'b0;
    localparam logic CFG_WINDOW = 1'b1;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_OFFSET = 2'd1,
        ERR_TRUNC  = 2'd2,
        ERR_RAGGED = 2'd3
    } err_t;

    typedef struct packed {
        logic [15:0]      offset;
        logic [CNT_W-1:0] count;
        logic [7:0]       lit;
        logic             with_lit;
        logic             ragged;
        logic             trunc;
        logic             last;
    } cmd_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_START,
        B_RD,
        B_WR,
        B_LIT,
        B_EMPTY,
        B_FIN
    } bstate_t;

endpackage

// ===== sv/lztd_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lztd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== sv/lztd_front.sv =====
`timescale 1ns / 1ps
// Front end: gathers stream bytes into triads and issues copy commands.
// Depends on lztd_pkg.
module lztd_front #(
    parameter int MAX_COPY = 511
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wide_format,
    input  logic          accept,
    input  logic [7:0]    in_byte,
    input  logic          end_of_stream,
    output logic          push,
    output lztd_pkg::cmd_t cmd
);
    import lztd_pkg::*;

    logic [4:0][7:0] bytes_reg, bytes_next, nb;
    logic [2:0]      fill_reg, fill_next;
    logic [2:0]      size, f, nf;
    logic [15:0]     off16, cnt16;
    logic            done;

    always_comb
    begin
        size = wide_format ? 3'd5 : 3'd3;
        f    = (fill_reg >= size) ? 3'd0 : fill_reg;
        nb   = (fill_reg >= size) ? '0 : bytes_reg;
        for (int i = 0; i < 5; i++)
        begin
            if (f == 3'(i))
            begin
                nb[i] = in_byte;
            end
        end
        nf = f + 3'd1;
        if (wide_format)
        begin
            off16   = {nb[1], nb[0]};
            cnt16   = {nb[3], nb[2]};
            cmd.lit = nb[4];
        end
        else
        begin
            off16   = {8'd0, nb[0]};
            cnt16   = {8'd0, nb[1]};
            cmd.lit = nb[2];
        end
        cmd.offset = off16;
        cmd.trunc  = (cnt16 > 16'(MAX_COPY));
        cmd.count  = cmd.trunc ? CNT_W'(MAX_COPY) : cnt16[CNT_W-1:0];
        cmd.last   = end_of_stream;
        cmd.with_lit = (nf == size);
        cmd.ragged   = (nf != size) && (nf != size - 3'd1);
        done = (nf == size) || end_of_stream;
        push = accept && done;
        bytes_next = bytes_reg;
        fill_next  = fill_reg;
        if (accept)
        begin
            bytes_next = done ? '0 : nb;
            fill_next  = done ? 3'd0 : nf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_reg <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            bytes_reg <= bytes_next;
            fill_reg  <= fill_next;
        end
    end
endmodule

// ===== sv/lztd_queue.sv =====
`timescale 1ns / 1ps
// Two-entry command queue between front end and copy engine.
// Depends on lztd_pkg.
module lztd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lztd_pkg::cmd_t wdata,
    input  logic           pop,
    output lztd_pkg::cmd_t rdata,
    output logic           full,
    output logic           empty
);
    import lztd_pkg::*;

    cmd_t       ent_reg [2];
    logic       rd_reg, rd_next, wr_reg, wr_next;
    logic [1:0] cnt_reg, cnt_next;

    always_comb
    begin
        rdata    = ent_reg[rd_reg];
        full     = (cnt_reg == 2'd2);
        empty    = (cnt_reg == 2'd0);
        rd_next  = pop ? ~rd_reg : rd_reg;
        wr_next  = push ? ~wr_reg : wr_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule

// ===== sv/lztd_back.sv =====
`timescale 1ns / 1ps
// Copy engine: walks history for each command, packs bytes into output words.
// Depends on lztd_pkg and lztd_ram.
module lztd_back #(
    parameter int HISTORY_DEPTH = 65536,
    parameter int OUT_LANES     = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [16:0]                   window_limit,
    input  logic                          q_empty,
    input  lztd_pkg::cmd_t                q_cmd,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [OUT_LANES-1:0][7:0]     out_lanes,
    output logic [3:0]                    out_count,
    output logic                          out_last,
    output logic [1:0]                    out_err
);
    import lztd_pkg::*;

    localparam int AW   = $clog2(HISTORY_DEPTH);
    localparam int PW   = $clog2(HISTORY_DEPTH + 1);
    localparam int CW   = (PW > 17) ? PW : 17;
    localparam int LCW  = $clog2(OUT_LANES + 1);

    bstate_t state_reg, state_next;
    cmd_t    cmd_reg, cmd_next;
    err_t    err_reg, err_next;
    logic [AW-1:0]    wp_reg, wp_next, src_reg, src_next, src_calc;
    logic [PW-1:0]    prod_reg, prod_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [PW:0]      sum;
    logic             bad_off;

    logic [OUT_LANES-1:0][7:0] acc_reg, acc_next, acc_fill;
    logic [LCW-1:0]            accn_reg, accn_next;
    logic [OUT_LANES-1:0][7:0] ol_reg, ol_next;
    logic [3:0]                oc_reg, oc_next;
    logic                      ov_reg, ov_next, olast_reg, olast_next;
    logic [1:0]                oerr_reg, oerr_next;

    logic       can_emit, emit, emit_byte_en, emit_final;
    logic [7:0] emit_byte;
    logic       ram_we, ram_re;
    logic [7:0] ram_wdata, ram_rdata;

    lztd_ram #(.WIDTH(8), .DEPTH(HISTORY_DEPTH)) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (src_reg),
        .rdata (ram_rdata)
    );

    assign can_emit = !ov_reg || !out_stall;

    always_comb
    begin
        bad_off = (cmd_reg.offset == 16'd0)
            || (CW'(cmd_reg.offset) > CW'(prod_reg))
            || (17'(cmd_reg.offset) > window_limit);
        sum = (PW+1)'(wp_reg) + (PW+1)'(HISTORY_DEPTH) - (PW+1)'(cmd_reg.offset);
        src_calc = (sum >= (PW+1)'(HISTORY_DEPTH))
            ? AW'(sum - (PW+1)'(HISTORY_DEPTH)) : AW'(sum);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = B_START;
                end
            end
            B_START:
            begin
                priority if (cmd_reg.ragged)
                begin
                    state_next = B_EMPTY;
                end
                else if (cmd_reg.count != '0 && !bad_off)
                begin
                    state_next = B_RD;
                end
                else if (cmd_reg.with_lit)
                begin
                    state_next = B_LIT;
                end
                else if (cmd_reg.count != '0 || cmd_reg.trunc)
                begin
                    state_next = B_EMPTY;
                end
                else
                begin
                    state_next = B_FIN;
                end
            end
            B_RD:
            begin
                state_next = B_WR;
            end
            B_WR:
            begin
                if (can_emit)
                begin
                    priority if (rem_reg != CNT_W'(1))
                    begin
                        state_next = B_RD;
                    end
                    else if (cmd_reg.with_lit)
                    begin
                        state_next = B_LIT;
                    end
                    else
                    begin
                        state_next = B_FIN;
                    end
                end
            end
            B_LIT, B_EMPTY:
            begin
                if (can_emit)
                begin
                    state_next = B_FIN;
                end
            end
            B_FIN:
            begin
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop        = 1'b0;
        ram_re       = 1'b0;
        ram_we       = 1'b0;
        ram_wdata    = ram_rdata;
        emit         = 1'b0;
        emit_byte_en = 1'b0;
        emit_final   = 1'b0;
        emit_byte    = ram_rdata;
        unique case (state_reg)
            B_IDLE:
            begin
                q_pop = !q_empty;
            end
            B_RD:
            begin
                ram_re = 1'b1;
            end
            B_WR:
            begin
                ram_we       = can_emit;
                emit         = can_emit;
                emit_byte_en = 1'b1;
                emit_final   = (rem_reg == CNT_W'(1)) && !cmd_reg.with_lit;
            end
            B_LIT:
            begin
                ram_we       = can_emit;
                ram_wdata    = cmd_reg.lit;
                emit         = can_emit;
                emit_byte_en = 1'b1;
                emit_byte    = cmd_reg.lit;
                emit_final   = 1'b1;
            end
            B_EMPTY:
            begin
                emit       = can_emit;
                emit_final = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        cmd_next  = cmd_reg;
        err_next  = err_reg;
        wp_next   = wp_reg;
        src_next  = src_reg;
        prod_next = prod_reg;
        rem_next  = rem_reg;
        acc_next  = acc_reg;
        accn_next = accn_reg;
        ol_next   = ol_reg;
        oc_next   = oc_reg;
        olast_next = olast_reg;
        oerr_next = oerr_reg;
        ov_next   = ov_reg && out_stall;
        acc_fill  = acc_reg;
        for (int i = 0; i < OUT_LANES; i++)
        begin
            if (accn_reg == LCW'(i))
            begin
                acc_fill[i] = emit_byte;
            end
        end

        if (q_pop)
        begin
            cmd_next = q_cmd;
        end
        if (state_reg == B_START)
        begin
            priority if (cmd_reg.ragged)
            begin
                err_next = ERR_RAGGED;
            end
            else if (cmd_reg.count != '0 && bad_off)
            begin
                err_next = ERR_OFFSET;
            end
            else if (cmd_reg.trunc)
            begin
                err_next = ERR_TRUNC;
            end
            else
            begin
                err_next = ERR_NONE;
            end
            src_next = src_calc;
            rem_next = cmd_reg.count;
        end
        if (ram_we)
        begin
            wp_next  = (wp_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
            src_next = (src_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : src_reg + AW'(1);
            rem_next = rem_reg - CNT_W'(1);
            if (prod_reg != PW'(HISTORY_DEPTH))
            begin
                prod_next = prod_reg + PW'(1);
            end
        end
        if (state_reg == B_FIN && cmd_reg.last)
        begin
            wp_next   = '0;
            prod_next = '0;
        end
        if (emit)
        begin
            if (emit_byte_en)
            begin
                if (emit_final || accn_reg == LCW'(OUT_LANES - 1))
                begin
                    ol_next    = acc_fill;
                    oc_next    = 4'(accn_reg) + 4'd1;
                    olast_next = emit_final;
                    oerr_next  = err_reg;
                    ov_next    = 1'b1;
                    acc_next   = '0;
                    accn_next  = '0;
                end
                else
                begin
                    acc_next  = acc_fill;
                    accn_next = accn_reg + LCW'(1);
                end
            end
            else
            begin
                ol_next    = '0;
                oc_next    = 4'd0;
                olast_next = 1'b1;
                oerr_next  = err_reg;
                ov_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            wp_reg    <= '0;
            prod_reg  <= '0;
            accn_reg  <= '0;
            acc_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            prod_reg  <= prod_next;
            accn_reg  <= accn_next;
            acc_reg   <= acc_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        err_reg   <= err_next;
        src_reg   <= src_next;
        rem_reg   <= rem_next;
        ol_reg    <= ol_next;
        oc_reg    <= oc_next;
        olast_reg <= olast_next;
        oerr_reg  <= oerr_next;
    end

    assign out_valid = ov_reg;
    assign out_lanes = ol_reg;
    assign out_count = oc_reg;
    assign out_last  = olast_reg;
    assign out_err   = oerr_reg;
endmodule

// ===== sv/lz77_triad_decompressor.sv =====
`timescale 1ns / 1ps
// LZ77 triad decompressor top level: config registers, front end, queue, copy engine.
// Depends on lztd_pkg, lztd_front, lztd_queue, lztd_back, lztd_ram.
//
// Input channel: one compressed byte per word (in_byte, end_of_stream).
// Output channel: words of up to OUT_LANES decoded bytes, byte_count valid
// from out_byte0, run_last on the final word of one input byte's run and
// error_code repeated on every word of that run.
// Config: write wide_format (index 0) or window_limit (index 1) when idle.
// Each copied byte passes through the history RAM read-then-write loop. A
// literal-only triad's command passes through the command queue and the
// copy engine's idle, start and literal states before its word reaches the
// output register. A two-entry command queue lets the front end take bytes
// while a copy runs. Decoded words pass through an output register; while
// out_stall holds a waiting word the copy engine keeps its place, the queue
// fills and in_stall rises. Reset clears triad assembly, the write pointer
// and produced count; history contents are never read unwritten.
module lz77_triad_decompressor #(
    parameter int HISTORY_DEPTH = 65536,
    parameter int OUT_LANES     = 8,
    parameter int MAX_COPY      = 511
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        end_of_stream,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte0,
    output logic [7:0]  out_byte1,
    output logic [7:0]  out_byte2,
    output logic [7:0]  out_byte3,
    output logic [7:0]  out_byte4,
    output logic [7:0]  out_byte5,
    output logic [7:0]  out_byte6,
    output logic [7:0]  out_byte7,
    output logic [3:0]  byte_count,
    output logic        run_last,
    output logic [1:0]  error_code,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [16:0] cfg_data
);
    import lztd_pkg::*;

    logic        wide_reg;
    logic [16:0] window_reg;
    logic        accept, push, pop, full, empty;
    cmd_t        cmd_in, cmd_out;
    logic [OUT_LANES-1:0][7:0] lanes;
    logic [7:0][7:0]           ob;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_reg   <= 1'b0;
            window_reg <= 17'd65536;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WIDE:   wide_reg   <= cfg_data[0];
                CFG_WINDOW: window_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    assign in_stall = full;
    assign accept   = in_valid && !full;

    lztd_front #(.MAX_COPY(MAX_COPY)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .wide_format   (wide_reg),
        .accept        (accept),
        .in_byte       (in_byte),
        .end_of_stream (end_of_stream),
        .push          (push),
        .cmd           (cmd_in)
    );

    lztd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cmd_in),
        .pop   (pop),
        .rdata (cmd_out),
        .full  (full),
        .empty (empty)
    );

    lztd_back #(.HISTORY_DEPTH(HISTORY_DEPTH), .OUT_LANES(OUT_LANES)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .window_limit (window_reg),
        .q_empty      (empty),
        .q_cmd        (cmd_out),
        .q_pop        (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_lanes    (lanes),
        .out_count    (byte_count),
        .out_last     (run_last),
        .out_err      (error_code)
    );

    always_comb
    begin
        ob = '0;
        for (int i = 0; i < OUT_LANES; i++)
        begin
            ob[i] = lanes[i];
        end
    end

    assign out_byte0 = ob[0];
    assign out_byte1 = ob[1];
    assign out_byte2 = ob[2];
    assign out_byte3 = ob[3];
    assign out_byte4 = ob[4];
    assign out_byte5 = ob[5];
    assign out_byte6 = ob[6];
    assign out_byte7 = ob[7];
endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Testbench for lz77_triad_decompressor: random and directed triad streams in
// both formats, output words checked against a behavioral decoder held in a class.
// Depends on lztd_pkg and the RTL of the decompressor.
module tb;
    import lztd_pkg::*;

    localparam int DEPTH    = 65536;
    localparam int LANES    = 8;
    localparam int COPY_MAX = 511;

    typedef struct packed {
        logic [7:0][7:0] bytes;
        logic [3:0]      count;
        logic            last;
        err_t            err;
    } word_t;

    class triad_scoreboard;
        bit          wide;
        int unsigned window;
        byte unsigned ring [DEPTH];
        int unsigned wp;
        int unsigned produced;
        byte unsigned held [5];
        int unsigned fill;
        word_t       pending [$];
        word_t       run [$];
        int unsigned lane;
        int          errors;

        function void clear();
            wide = 0;
            window = DEPTH;
            wp = 0;
            produced = 0;
            fill = 0;
            errors = 0;
            pending.delete();
        endfunction

        function void push_byte(byte unsigned b);
            word_t w;
            if (lane == 0)
            begin
                w = '0;
                run.push_back(w);
            end
            w = run[$];
            w.bytes[lane] = b;
            w.count = 4'(lane + 1);
            run[$] = w;
            lane = (lane + 1) % LANES;
            ring[wp] = b;
            wp = (wp + 1) % DEPTH;
            if (produced < DEPTH)
                produced++;
        endfunction

        function err_t decode(bit with_lit);
            int unsigned off, cnt;
            err_t e;
            e = ERR_NONE;
            if (wide)
            begin
                off = held[0] | (held[1] << 8);
                cnt = held[2] | (held[3] << 8);
            end
            else
            begin
                off = held[0];
                cnt = held[1];
            end
            if (cnt > COPY_MAX)
            begin
                cnt = COPY_MAX;
                e = ERR_TRUNC;
            end
            if (cnt > 0 && (off == 0 || off > produced || off > window))
            begin
                cnt = 0;
                e = ERR_OFFSET;
            end
            for (int i = 0; i < cnt; i++)
                push_byte(ring[(wp + DEPTH - off) % DEPTH]);
            if (with_lit)
                push_byte(held[wide ? 4 : 2]);
            return e;
        endfunction

        function void note_input(byte unsigned b, bit eos);
            int unsigned size;
            err_t e;
            bit done;
            word_t w;
            size = wide ? 5 : 3;
            e = ERR_NONE;
            done = 0;
            run.delete();
            lane = 0;
            if (fill >= size)
                fill = 0;
            held[fill] = b;
            fill++;
            if (fill == size)
            begin
                e = decode(1);
                done = 1;
            end
            else if (eos)
            begin
                if (fill == size - 1)
                    e = decode(0);
                else
                    e = ERR_RAGGED;
                done = 1;
            end
            if (done)
                fill = 0;
            if (eos)
            begin
                wp = 0;
                produced = 0;
            end
            if (e != ERR_NONE && run.size() == 0)
                run.push_back('0);
            foreach (run[k])
            begin
                w = run[k];
                w.err = e;
                w.last = (k == run.size() - 1);
                pending.push_back(w);
            end
        endfunction

        function void check_word(word_t got);
            word_t exp;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected word, actual %h", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            for (int i = 0; i < LANES; i++)
                if (got.bytes[i] !== exp.bytes[i])
                begin
                    $display("%0t: out_byte%0d expected %h actual %h", $time, i,
                             exp.bytes[i], got.bytes[i]);
                    errors++;
                end
            if (got.count !== exp.count)
            begin
                $display("%0t: byte_count expected %0d actual %0d", $time,
                         exp.count, got.count);
                errors++;
            end
            if (got.last !== exp.last)
            begin
                $display("%0t: run_last expected %0d actual %0d", $time,
                         exp.last, got.last);
                errors++;
            end
            if (got.err !== exp.err)
            begin
                $display("%0t: error_code expected %0d actual %0d", $time,
                         exp.err, got.err);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  in_byte;
    logic        end_of_stream;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  ob [8];
    logic [3:0]  byte_count;
    logic        run_last;
    logic [1:0]  error_code;
    logic        cfg_we;
    logic        cfg_index;
    logic [16:0] cfg_data;

    triad_scoreboard sb;
    int  cycles;
    bit  sending;
    bit  long_hold;

    lz77_triad_decompressor dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .in_byte(in_byte), .end_of_stream(end_of_stream),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_byte0(ob[0]), .out_byte1(ob[1]), .out_byte2(ob[2]), .out_byte3(ob[3]),
        .out_byte4(ob[4]), .out_byte5(ob[5]), .out_byte6(ob[6]), .out_byte7(ob[7]),
        .byte_count(byte_count), .run_last(run_last), .error_code(error_code),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // hold the word until taken, then idle for a random gap or keep valid high
    task automatic send_byte(byte unsigned b, bit eos);
        int gap;
        in_valid <= 1;
        in_byte <= b;
        end_of_stream <= eos;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(b, eos);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        if (gap != 0)
        begin
            in_valid <= 0;
            in_byte <= 8'($urandom);
            end_of_stream <= 1'($urandom);
            repeat (gap)
                @(posedge clk);
        end
    endtask

    task automatic idle_input();
        in_valid <= 0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        idle_input();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);
    endtask

    task automatic write_reg(bit idx, int unsigned val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val[16:0];
        @(posedge clk);
        cfg_we <= 0;
        if (idx == CFG_WIDE)
            sb.wide = val[0];
        else
            sb.window = val;
        @(posedge clk);
    endtask

    // one well-formed triad with random content, mostly small counts
    task automatic send_triad(bit eos_at_end, bit drop_lit);
        int unsigned off, cnt, size;
        byte unsigned t [5];
        off = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                           : $urandom_range(1, 20);
        cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 700)
                                           : $urandom_range(0, 24);
        if (!sb.wide)
        begin
            off &= 8'hff;
            cnt &= 8'hff;
        end
        t[0] = off[7:0];
        if (sb.wide)
        begin
            t[1] = off[15:8];
            t[2] = cnt[7:0];
            t[3] = cnt[15:8];
            t[4] = 8'($urandom);
        end
        else
        begin
            t[1] = cnt[7:0];
            t[2] = 8'($urandom);
        end
        size = sb.wide ? 5 : 3;
        if (drop_lit)
            size--;
        for (int i = 0; i < size; i++)
            send_byte(t[i], eos_at_end && i == size - 1);
    endtask

    initial
    begin
        rst_n = 0;
        in_valid = 0;
        in_byte = 0;
        end_of_stream = 0;
        cfg_we = 0;
        cfg_index = 0;
        cfg_data = 0;
        sending = 1;
        long_hold = 0;
        sb = new();
        sb.clear();
        repeat (6)
            @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed narrow: literals, overlap copy, bad offset, truncation-free max, copy without literal, ragged end
        send_byte(8'h00, 0); send_byte(8'h00, 0); send_byte(8'hff, 0);
        send_byte(8'h00, 0); send_byte(8'h00, 0); send_byte(8'h5a, 0);
        send_byte(8'h01, 0); send_byte(8'hff, 0); send_byte(8'h33, 0);
        send_byte(8'h00, 0); send_byte(8'h04, 0); send_byte(8'h11, 0);
        send_byte(8'hff, 0); send_byte(8'h04, 0); send_byte(8'h22, 0);
        send_byte(8'h02, 0); send_byte(8'h03, 1);
        send_byte(8'hab, 1);
        wait_drained();

        // directed wide: truncated count, window bound, ragged end
        write_reg(CFG_WIDE, 1);
        write_reg(CFG_WINDOW, 1);
        send_byte(8'h00, 0); send_byte(8'h00, 0); send_byte(8'h00, 0);
        send_byte(8'h00, 0); send_byte(8'h80, 0);
        send_byte(8'h01, 0); send_byte(8'h00, 0); send_byte(8'hff, 0);
        send_byte(8'hff, 0); send_byte(8'h7f, 0);
        send_byte(8'h02, 0); send_byte(8'h00, 0); send_byte(8'h01, 0);
        send_byte(8'h00, 0); send_byte(8'h01, 0);
        send_byte(8'hff, 0); send_byte(8'hff, 1);
        wait_drained();

        for (int phase = 0; phase < 6; phase++)
        begin
            write_reg(CFG_WIDE, phase[0]);
            case (phase)
                0: write_reg(CFG_WINDOW, 65536);
                1: write_reg(CFG_WINDOW, 1);
                2: write_reg(CFG_WINDOW, 17'h1ffff);
                default: write_reg(CFG_WINDOW, $urandom_range(1, 65536));
            endcase
            if (phase == 2)
                long_hold = 1;
            for (int n = 0; n < 3; n++)
            begin
                case ($urandom_range(0, 9))
                    0: send_byte(8'($urandom), 1'($urandom_range(0, 1)));
                    1: send_triad(1, 1);
                    2: send_triad(1, 0);
                    default: send_triad(0, 0);
                endcase
            end
            send_triad(1, 0);
            if (phase == 3)
            begin
                // stall mid-triad until the block is empty
                send_byte(8'h00, 0);
                idle_input();
                while (sb.pending.size() != 0)
                    @(posedge clk);
                send_byte(8'h00, 1);
            end
            wait_drained();
        end
        sending = 0;
    end

    initial
    begin
        int hold;
        out_stall = 1;
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                long_hold = 0;
                out_stall <= 1;
                repeat (400)
                    @(posedge clk);
            end
            hold = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
            if (hold != 0)
            begin
                out_stall <= 1;
                repeat (hold)
                    @(posedge clk);
            end
            out_stall <= 0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_word({ob[7], ob[6], ob[5], ob[4], ob[3], ob[2], ob[1], ob[0],
                           byte_count, run_last, err_t'(error_code)});
    end

    initial
    begin
        cycles = 0;
        @(posedge rst_n);
        while (sending && cycles < 2000000)
        begin
            @(posedge clk);
            cycles++;
        end
        if (sending)
        begin
            $display("simulation failed");
            $finish;
        end
        else
        begin
            repeat (50)
                @(posedge clk);
            if (sb.errors == 0 && sb.pending.size() == 0)
                $display("simulation ok");
            else
                $display("simulation failed");
            $finish;
        end
    end
endmodule

// ===== filelist.f =====
sv/lztd_pkg.sv
sv/lztd_ram.sv
sv/lztd_front.sv
sv/lztd_queue.sv
sv/lztd_back.sv
sv/lz77_triad_decompressor.sv
test/tb.sv
